[design/tga_pixel_rle_decoder_defines.svh]
// ----------------------------------------------------------------------------
// TGA RLE decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef TGA_PIXEL_RLE_DECODER_DEFINES_SVH
`define TGA_PIXEL_RLE_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TGA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tga decoder check failed");

// next-cycle implication, disabled during reset
`define TGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tga decoder check failed");

`endif

[design/tga_rle_pkg.sv]
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Register indexes, field widths and the result word type.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int COUNT_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd2;

	localparam logic [2:0] BPP_RESET = 3'd4;
	localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = 32'd1;
	localparam logic [7:0] REPEAT_FLAG = 8'd128;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] MAX_RUN = 8'd128;

	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic [7:0] chan3;
		logic [7:0] repeat_res;
		logic last_of_image;
	} pixel_t;

endpackage

[design/tga_pixel_rle_decoder.sv]
// ----------------------------------------------------------------------------
// TGA pixel RLE decoder
// Rebuilds pixels from the raw or run-length encoded pixel data of a TGA file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one data_byte word per accepted handshake (in_valid high,
//   in_stall low). Output channel: one pixel word (chan0..chan3, repeat_res,
//   last_of_image) per completed pixel; header bytes and bytes after the
//   image end give no word.
//   Config port: cfg_wr_en with cfg_index 0 rle_mode, 1 bytes_per_pixel,
//   2 pixel_count. Any valid write restarts decoding. Write only when idle.
//   Path: an accepted byte lands in the input register; the word of the pixel
//   that it completes is then written into the output register.
//   Throughput: one byte per cycle unless out_stall holds a word, set by the
//   single pass from input register via packet/pixel update to output register.
//   Stall: when out_stall holds a word, the output register keeps it; the
//   input register still drains into an empty output slot, and in_stall rises
//   only when the input register holds a byte and the output word is stuck.
//   Reset: rle_mode 0, bytes_per_pixel 4, pixel_count 1, both registers empty.
// ----------------------------------------------------------------------------
module tga_pixel_rle_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         chan0,
	output logic [7:0]                         chan1,
	output logic [7:0]                         chan2,
	output logic [7:0]                         chan3,
	output logic [7:0]                         repeat_res,
	output logic                               last_of_image
);
	import tga_rle_pkg::*;

	// configuration
	logic               rle_mode_q;
	logic [2:0]         bpp_q;
	logic [COUNT_W-1:0] pixel_count_q;
	logic               cfg_hit;

	// decode state
	logic [7:0]         packet_left_q;
	logic               in_repeat_q;
	logic [1:0]         byte_index_q;
	logic [23:0]        partial_q;
	logic [COUNT_W-1:0] pixels_left_q;
	logic               done_q;

	// input register
	logic               valid_s1;
	logic [7:0]         byte_s1;

	// output register
	logic               out_valid_q;
	pixel_t             out_q;

	// per-byte decode
	logic               out_free;
	logic               take;
	logic               is_header;
	logic [2:0]         n_eff;
	logic [2:0]         byte_next;
	logic               pix_end;
	logic               produce;
	logic [23:0]        partial_d;
	logic [31:0]        partial_ext;
	logic [7:0]         ch [4];
	logic [7:0]         rep;
	logic [7:0]         rep_trim;
	logic [COUNT_W-1:0] pixels_left_d;
	pixel_t             pix_d;

	assign cfg_hit = cfg_wr_en && (cfg_index == REG_RLE_MODE || cfg_index == REG_BPP
		|| cfg_index == REG_PIXEL_COUNT);

	// output slot can take a new word this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign take = valid_s1 && out_free && !done_q;
	assign is_header = rle_mode_q && (packet_left_q == 8'd0);

	always_comb begin
		case (bpp_q) inside
			3'd0, 3'd1: n_eff = 3'd1;
			3'd2: n_eff = 3'd2;
			3'd3: n_eff = 3'd3;
			default: n_eff = 3'd4;
		endcase
	end

	assign byte_next = {1'b0, byte_index_q} + 3'd1;
	assign pix_end = (byte_next >= n_eff);
	assign produce = take && !is_header && pix_end;

	// byte lands in its slot of the partial pixel
	always_comb begin
		partial_d = partial_q;
		case (byte_index_q)
			2'd0: partial_d[7:0] = byte_s1;
			2'd1: partial_d[15:8] = byte_s1;
			2'd2: partial_d[23:16] = byte_s1;
			default: partial_d = partial_q;
		endcase
	end

	// earlier bytes, this byte, then opaque fill; grey copies to all four
	assign partial_ext = {ALPHA_OPAQUE, partial_q};
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (n_eff == 3'd1) begin
				ch[k] = byte_s1;
			end else if (k < int'(byte_index_q)) begin
				ch[k] = partial_ext[8*k +: 8];
			end else if (k == int'(byte_index_q)) begin
				ch[k] = byte_s1;
			end else begin
				ch[k] = ALPHA_OPAQUE;
			end
		end
	end

	// run length, trimmed at the image end
	assign rep = (rle_mode_q && in_repeat_q) ? packet_left_q : 8'd1;
	assign rep_trim = (pixels_left_q < {{(COUNT_W-8){1'b0}}, rep}) ?
		pixels_left_q[7:0] : rep;
	assign pixels_left_d = pixels_left_q - {{(COUNT_W-8){1'b0}}, rep_trim};

	always_comb begin
		pix_d.chan0 = ch[0];
		pix_d.chan1 = ch[1];
		pix_d.chan2 = ch[2];
		pix_d.chan3 = ch[3];
		pix_d.repeat_res = rep_trim;
		pix_d.last_of_image = (pixels_left_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q <= 1'b0;
			bpp_q <= BPP_RESET;
			pixel_count_q <= PIXEL_COUNT_RESET;
			packet_left_q <= '0;
			in_repeat_q <= 1'b0;
			byte_index_q <= '0;
			partial_q <= '0;
			pixels_left_q <= PIXEL_COUNT_RESET;
			done_q <= 1'b0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_RLE_MODE: rle_mode_q <= cfg_data[0];
				REG_BPP: bpp_q <= cfg_data[2:0];
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data;
				default: rle_mode_q <= rle_mode_q;
			endcase
			// restart; pixels_left picks up the new count if that is the one written
			packet_left_q <= '0;
			in_repeat_q <= 1'b0;
			byte_index_q <= '0;
			partial_q <= '0;
			if (cfg_index == REG_PIXEL_COUNT) begin
				pixels_left_q <= cfg_data;
				done_q <= (cfg_data == '0);
			end else begin
				pixels_left_q <= pixel_count_q;
				done_q <= (pixel_count_q == '0);
			end
		end else if (take) begin
			if (is_header) begin
				// header: literal below 128, else repeat run
				if (byte_s1 < REPEAT_FLAG) begin
					packet_left_q <= byte_s1 + 8'd1;
					in_repeat_q <= 1'b0;
				end else begin
					packet_left_q <= byte_s1 - (MAX_RUN - 8'd1);
					in_repeat_q <= 1'b1;
				end
			end else if (!pix_end) begin
				partial_q <= partial_d;
				byte_index_q <= byte_index_q + 2'd1;
			end else begin
				partial_q <= '0;
				byte_index_q <= '0;
				if (rle_mode_q) begin
					packet_left_q <= in_repeat_q ? 8'd0 : packet_left_q - 8'd1;
				end
				pixels_left_q <= pixels_left_d;
				if (pixels_left_d == '0) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// input register: refills whenever it is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_q <= pix_d;
		end
	end

	assign out_valid = out_valid_q;
	assign chan0 = out_q.chan0;
	assign chan1 = out_q.chan1;
	assign chan2 = out_q.chan2;
	assign chan3 = out_q.chan3;
	assign repeat_res = out_q.repeat_res;
	assign last_of_image = out_q.last_of_image;

endmodule

[design/tga_rle_chk.sv]
// ----------------------------------------------------------------------------
// TGA RLE decoder checker
// Port-level assertions, bound to the decoder top level.
// ----------------------------------------------------------------------------
`include "tga_pixel_rle_decoder_defines.svh"

module tga_rle_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] data_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] chan0,
	input logic [7:0] chan1,
	input logic [7:0] chan2,
	input logic [7:0] chan3,
	input logic [7:0] repeat_res,
	input logic       last_of_image
);
	import tga_rle_pkg::*;

	// stalled input word stays put
	`TGA_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(data_byte))

	// held word stays put
	`TGA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({chan0, chan1, chan2, chan3, repeat_res, last_of_image}))

	// a run never reports zero or more than one packet's worth
	`TGA_ASSERT_IMPLY(a_rep_range, clk, arst_n, out_valid, repeat_res != 8'd0 && repeat_res <= MAX_RUN)

	// an empty output slot never back-pressures the input
	`TGA_ASSERT_IMPLY(a_no_idle_stall, clk, arst_n, !out_valid, !in_stall)

endmodule

bind tga_pixel_rle_decoder tga_rle_chk u_tga_rle_chk (.*);
